// File: rtl/inverse_cdf_angle_sampler_macros.svh
// assertion macros for the inverse cdf angle sampler
`ifndef INVERSE_CDF_ANGLE_SAMPLER_MACROS_SVH
`define INVERSE_CDF_ANGLE_SAMPLER_MACROS_SVH

// implication checked on every clock edge outside reset
`define ICAS_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// implication checked in the cycle after the left side holds
`define ICAS_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// File: rtl/icas_pkg.sv
// shared types, codes and constants of the inverse cdf angle sampler
`timescale 1ns / 1ps
package icas_pkg;
   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int ZEN_W = 15;
   localparam int AZ_W = 16;
   localparam int WEIGHT_W = 32;
   localparam int DRAW_W = 32;
   localparam int CUM_W = 42;
   localparam int ST_W = 3;
   localparam int FRAC_W = 16;
   localparam logic [AZ_W:0] AZ_FULL = 17'd46080;
   localparam logic [AZ_W:0] AZ_HALF = 17'd23040;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_LOAD = 2'd1;

   localparam logic [ST_W-1:0] ST_SAMPLED = 3'd0;
   localparam logic [ST_W-1:0] ST_STORED = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL = 3'd2;
   localparam logic [ST_W-1:0] ST_NO_TABLE = 3'd3;
   localparam logic [ST_W-1:0] ST_CLEARED = 3'd4;

   typedef struct packed {
      logic clear_count;
      logic load_write;
      logic latch_draw;
      logic total_read;
      logic total_latch;
      logic mult_lo;
      logic mult_hi;
      logic search_init;
      logic search_step;
      logic pair_read;
      logic pair_latch;
      logic div_init;
      logic div_step;
      logic blend_prep;
      logic blend_mul;
      logic blend_sum;
      logic set_out;
      logic [ST_W-1:0] out_status;
   } cmd_type;

   typedef struct packed {
      logic table_full;
      logic table_empty;
      logic total_zero;
      logic search_done;
      logic hit_first;
      logic pair_bad;
      logic div_done;
   } stat_type;
endpackage

// File: rtl/icas_datapath.sv
// datapath of the inverse cdf angle sampler: tables, search, divider, blend
`timescale 1ns / 1ps
module icas_datapath #(
   parameter int TABLE_DEPTH = icas_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  icas_pkg::cmd_type             cmd,
   output icas_pkg::stat_type            stat,
   input  logic [icas_pkg::ZEN_W-1:0]    req_bin_zenith,
   input  logic [icas_pkg::AZ_W-1:0]     req_bin_azimuth,
   input  logic [icas_pkg::WEIGHT_W-1:0] req_bin_weight,
   input  logic [icas_pkg::DRAW_W-1:0]   req_uniform_draw,
   output logic [icas_pkg::ZEN_W-1:0]    out_zenith,
   output logic [icas_pkg::AZ_W-1:0]     out_azimuth,
   output logic [icas_pkg::ST_W-1:0]     out_status
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int CUM_W = icas_pkg::CUM_W;
   localparam int ZW = icas_pkg::ZEN_W;
   localparam int AZW = icas_pkg::AZ_W;
   localparam int FW = icas_pkg::FRAC_W;
   localparam int ENT_W = CUM_W + AZW + ZW;
   localparam int PW = AZW + FW + 2;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic [ENT_W-1:0] mem [TABLE_DEPTH];
   logic [ENT_W-1:0] rd_ff;
   logic [AW-1:0]    rd_addr;

   logic [CW-1:0]    count_ff, count_in;
   logic [CUM_W-1:0] last_ff, last_in;
   logic [31:0]      draw_ff;
   logic [CUM_W-1:0] total_ff;
   logic [CUM_W+31:0] prod_ff, prod_in;
   logic [CUM_W-1:0] target_ff;
   logic [CW-1:0]    left_ff, left_in, right_ff, right_in;
   logic [CW-1:0]    mid;
   logic [CUM_W-1:0] c2_ff, c1_ff;
   logic [ZW-1:0]    z1_ff, z2_ff;
   logic [AZW-1:0]   a1_ff, a2_ff;
   logic             pair_phase_ff;
   logic [CUM_W-1:0] den_ff, rem_ff;
   logic [FW:0]      quo_ff;
   logic [4:0]       div_cnt_ff;
   logic [CUM_W:0]   rem_sh;
   logic [FW:0]      alpha;
   logic [FW:0]      inv_alpha;
   logic [AZW:0]     ba1_ff, ba2_ff;
   logic [AZW+FW+1:0] zp1_ff, zp2_ff, ap1_ff, ap2_ff;
   logic [AZW+FW+2:0] zsum, asum;
   logic [ZW-1:0]    zres_ff;
   logic [AZW:0]     ares_ff;
   logic [ZW-1:0]    oz_ff;
   logic [AZW-1:0]   oa_ff;
   logic [icas_pkg::ST_W-1:0] os_ff;

   assign mid = CW'(({1'b0, left_ff} + {1'b0, right_ff}) >> 1);

   always_comb begin
      rd_addr = mid[AW-1:0];
      if (cmd.total_read) begin
         rd_addr = AW'(count_ff - 1'b1);
      end else if (cmd.pair_read) begin
         rd_addr = pair_phase_ff ? AW'(left_ff - 1'b1) : left_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_write) begin
         mem[count_ff[AW-1:0]] <= {last_in, req_bin_azimuth, req_bin_zenith};
      end
      rd_ff <= mem[rd_addr];
   end

   assign last_in = ((count_ff == '0) ? '0 : last_ff) + CUM_W'(req_bin_weight);

   always_comb begin
      count_in = count_ff;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.load_write) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      if (cmd.load_write) begin
         last_ff <= last_in;
      end
   end

   // target = draw * total >> 32, formed from two partial products
   always_comb begin
      prod_in = prod_ff;
      if (cmd.mult_lo) begin
         prod_in = (CUM_W+32)'({32'd0, draw_ff} * {32'd0, total_ff[31:0]});
      end else if (cmd.mult_hi) begin
         prod_in = prod_ff + {CUM_W'({{(CUM_W-32){1'b0}}, draw_ff} *
                                     {32'd0, total_ff[CUM_W-1:32]}), 32'd0};
      end
   end

   assign rem_sh = {rem_ff, 1'b0};
   assign alpha = quo_ff;
   assign inv_alpha = (FW+1)'(1 << FW) - alpha;

   always_comb begin
      left_in = left_ff;
      right_in = right_ff;
      if (cmd.search_init) begin
         left_in = '0;
         right_in = count_ff - 1'b1;
      end else if (cmd.search_step) begin
         if (rd_ff[ENT_W-1 -: CUM_W] < target_ff) begin
            left_in = mid + 1'b1;
         end else begin
            right_in = mid;
         end
      end
   end

   assign zsum = zp1_ff + zp2_ff + (AZW+FW+3)'(1 << (FW-1));
   assign asum = ap1_ff + ap2_ff + (AZW+FW+3)'(1 << (FW-1));

   always_ff @(posedge clock) begin
      if (cmd.latch_draw) begin
         draw_ff <= req_uniform_draw;
      end
      if (cmd.total_read) begin
         pair_phase_ff <= 1'b0;
      end
      if (cmd.total_latch) begin
         total_ff <= rd_ff[ENT_W-1 -: CUM_W];
      end
      prod_ff <= prod_in;
      if (cmd.search_init) begin
         target_ff <= prod_ff[CUM_W+31:32];
      end
      left_ff <= left_in;
      right_ff <= right_in;
      if (cmd.pair_read) begin
         pair_phase_ff <= ~pair_phase_ff;
      end
      if (cmd.pair_latch) begin
         if (!pair_phase_ff) begin
            c1_ff <= rd_ff[ENT_W-1 -: CUM_W];
            z1_ff <= rd_ff[ZW-1:0];
            a1_ff <= rd_ff[ZW +: AZW];
         end else begin
            c2_ff <= rd_ff[ENT_W-1 -: CUM_W];
            z2_ff <= rd_ff[ZW-1:0];
            a2_ff <= rd_ff[ZW +: AZW];
         end
      end
      if (cmd.div_init) begin
         rem_ff <= target_ff - c1_ff;
         den_ff <= c2_ff - c1_ff;
         quo_ff <= '0;
         div_cnt_ff <= 5'd0;
      end else if (cmd.div_step) begin
         // restoring division, one quotient bit per cycle
         if (div_cnt_ff == 5'd0) begin
            if (rem_ff >= den_ff) begin
               rem_ff <= rem_ff - den_ff;
               quo_ff <= {{FW{1'b0}}, 1'b1};
            end
         end else if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= CUM_W'(rem_sh - {1'b0, den_ff});
            quo_ff <= {quo_ff[FW-1:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[CUM_W-1:0];
            quo_ff <= {quo_ff[FW-1:0], 1'b0};
         end
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      if (cmd.blend_prep) begin
         ba1_ff <= {1'b0, a1_ff};
         ba2_ff <= {1'b0, a2_ff};
         if (a2_ff > a1_ff) begin
            if ((AZW+1)'(a2_ff - a1_ff) > icas_pkg::AZ_HALF) begin
               ba1_ff <= {1'b0, a1_ff} + icas_pkg::AZ_FULL;
            end
         end else if ((AZW+1)'(a1_ff - a2_ff) > icas_pkg::AZ_HALF) begin
            ba2_ff <= {1'b0, a2_ff} + icas_pkg::AZ_FULL;
         end
      end
      if (cmd.blend_mul) begin
         zp1_ff <= PW'(z1_ff) * PW'(inv_alpha);
         zp2_ff <= PW'(z2_ff) * PW'(alpha);
         ap1_ff <= PW'(ba1_ff) * PW'(inv_alpha);
         ap2_ff <= PW'(ba2_ff) * PW'(alpha);
      end
      if (cmd.blend_sum) begin
         zres_ff <= zsum[FW +: ZW];
         ares_ff <= asum[FW +: AZW+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         os_ff <= '0;
      end else if (cmd.set_out) begin
         os_ff <= cmd.out_status;
      end
      if (cmd.set_out) begin
         oz_ff <= '0;
         oa_ff <= '0;
         if (cmd.out_status == icas_pkg::ST_SAMPLED) begin
            if (stat.hit_first || stat.pair_bad) begin
               oz_ff <= z2_ff;
               oa_ff <= ({1'b0, a2_ff} >= icas_pkg::AZ_FULL) ?
                  AZW'({1'b0, a2_ff} - icas_pkg::AZ_FULL) : a2_ff;
            end else begin
               oz_ff <= zres_ff;
               oa_ff <= (ares_ff >= icas_pkg::AZ_FULL) ?
                  AZW'(ares_ff - icas_pkg::AZ_FULL) : ares_ff[AZW-1:0];
            end
         end
      end
   end

   assign stat.table_full = (count_ff >= DEPTH_C);
   assign stat.table_empty = (count_ff == '0);
   assign stat.total_zero = (rd_ff[ENT_W-1 -: CUM_W] == '0);
   assign stat.search_done = (left_ff >= right_ff);
   assign stat.hit_first = (left_ff == '0);
   assign stat.pair_bad = (c2_ff <= c1_ff) || (target_ff < c1_ff);
   assign stat.div_done = (div_cnt_ff == 5'(FW + 1));

   assign out_zenith = oz_ff;
   assign out_azimuth = oa_ff;
   assign out_status = os_ff;
endmodule

// File: rtl/icas_control.sv
// controller state machine of the inverse cdf angle sampler
`timescale 1ns / 1ps
`include "inverse_cdf_angle_sampler_macros.svh"
module icas_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  icas_pkg::stat_type stat,
   output icas_pkg::cmd_type  cmd
);
   typedef enum logic [4:0] {
      S_IDLE, S_TOT_RD, S_TOT_WAIT, S_MUL_LO, S_MUL_HI, S_SINIT, S_SRD, S_SWAIT,
      S_SSTEP, S_P2RD, S_P1RD, S_P2LAT, S_P1LAT, S_DINIT, S_DSTEP, S_PREP,
      S_MUL, S_SUM, S_SET, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.latch_draw = 1'b1;
               if (req_action == icas_pkg::ACT_CLEAR) begin
                  cmd.clear_count = 1'b1;
                  cmd.set_out = 1'b1;
                  cmd.out_status = icas_pkg::ST_CLEARED;
                  rsp_valid_in = 1'b1;
               end else if (req_action == icas_pkg::ACT_LOAD) begin
                  cmd.set_out = 1'b1;
                  rsp_valid_in = 1'b1;
                  if (stat.table_full) begin
                     cmd.out_status = icas_pkg::ST_FULL;
                  end else begin
                     cmd.load_write = 1'b1;
                     cmd.out_status = icas_pkg::ST_STORED;
                  end
               end else if (stat.table_empty) begin
                  cmd.set_out = 1'b1;
                  cmd.out_status = icas_pkg::ST_NO_TABLE;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = S_TOT_RD;
               end
            end
         end
         S_TOT_RD: begin
            cmd.total_read = 1'b1;
            state_in = S_TOT_WAIT;
         end
         S_TOT_WAIT: begin
            if (stat.total_zero) begin
               cmd.set_out = 1'b1;
               cmd.out_status = icas_pkg::ST_NO_TABLE;
               state_in = S_OUT;
            end else begin
               cmd.total_latch = 1'b1;
               state_in = S_MUL_LO;
            end
         end
         S_MUL_LO: begin
            cmd.mult_lo = 1'b1;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mult_hi = 1'b1;
            state_in = S_SINIT;
         end
         S_SINIT: begin
            cmd.search_init = 1'b1;
            state_in = S_SRD;
         end
         S_SRD: begin
            if (stat.search_done) begin
               state_in = S_P2RD;
            end else begin
               state_in = S_SWAIT;
            end
         end
         S_SWAIT: state_in = S_SSTEP;
         S_SSTEP: begin
            cmd.search_step = 1'b1;
            state_in = S_SRD;
         end
         S_P2RD: begin
            cmd.pair_read = 1'b1;
            state_in = stat.hit_first ? S_P2LAT : S_P1RD;
         end
         S_P1RD: begin
            cmd.pair_read = 1'b1;
            cmd.pair_latch = 1'b1;
            state_in = S_P2LAT;
         end
         S_P2LAT: begin
            cmd.pair_latch = 1'b1;
            state_in = S_P1LAT;
         end
         S_P1LAT: state_in = S_DINIT;
         S_DINIT: begin
            if (stat.hit_first || stat.pair_bad) begin
               cmd.set_out = 1'b1;
               cmd.out_status = icas_pkg::ST_SAMPLED;
               state_in = S_OUT;
            end else begin
               cmd.div_init = 1'b1;
               state_in = S_DSTEP;
            end
         end
         S_DSTEP: begin
            if (stat.div_done) begin
               state_in = S_PREP;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_PREP: begin
            cmd.blend_prep = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.blend_mul = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.blend_sum = 1'b1;
            state_in = S_SET;
         end
         S_SET: begin
            cmd.set_out = 1'b1;
            cmd.out_status = icas_pkg::ST_SAMPLED;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ICAS_ASSERT_IMP(a_busy_stalls, clock, reset, state_ff != S_IDLE, req_stall)
   `ICAS_ASSERT_NEXT(a_held_rsp, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff)
   `ICAS_ASSERT_IMP(a_load_not_full, clock, reset, cmd.load_write, !stat.table_full)
   `ICAS_ASSERT_IMP(a_step_in_divide, clock, reset, cmd.div_step, state_ff == S_DSTEP)
endmodule

// File: rtl/inverse_cdf_angle_sampler.sv
// top level of the inverse cdf angle sampler
// channel | direction | payload
// req     | in        | action, bin_zenith, bin_azimuth, bin_weight, uniform_draw
// rsp     | out       | out_zenith, out_azimuth, status
// clear and append give a result in the cycle after the transaction is taken
// the length of a sample is set by the table's single read port during the search
// and by the one-bit-per-cycle alpha divider
// reset is synchronous and clears the bin count; table entries need no clearing
// a stalled result holds the block until it is taken
`timescale 1ns / 1ps
module inverse_cdf_angle_sampler #(
   parameter int TABLE_DEPTH = icas_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_action,
   input  logic [icas_pkg::ZEN_W-1:0]    req_bin_zenith,
   input  logic [icas_pkg::AZ_W-1:0]     req_bin_azimuth,
   input  logic [icas_pkg::WEIGHT_W-1:0] req_bin_weight,
   input  logic [icas_pkg::DRAW_W-1:0]   req_uniform_draw,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [icas_pkg::ZEN_W-1:0]    rsp_out_zenith,
   output logic [icas_pkg::AZ_W-1:0]     rsp_out_azimuth,
   output logic [icas_pkg::ST_W-1:0]     rsp_status
);
   icas_pkg::cmd_type  cmd;
   icas_pkg::stat_type stat;

   icas_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .stat(stat), .cmd(cmd)
   );

   icas_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_bin_zenith(req_bin_zenith), .req_bin_azimuth(req_bin_azimuth),
      .req_bin_weight(req_bin_weight), .req_uniform_draw(req_uniform_draw),
      .out_zenith(rsp_out_zenith), .out_azimuth(rsp_out_azimuth),
      .out_status(rsp_status)
   );
endmodule

// File: test/tb_inverse_cdf_angle_sampler.sv
// testbench for the inverse cdf angle sampler: directed table plus random traffic
`timescale 1ns / 1ps
module tb_inverse_cdf_angle_sampler;
   localparam int DEPTH = icas_pkg::TABLE_DEPTH_DEFAULT;
   localparam int ZW = icas_pkg::ZEN_W;
   localparam int AZW = icas_pkg::AZ_W;
   localparam int WW = icas_pkg::WEIGHT_W;
   localparam int DW = icas_pkg::DRAW_W;
   localparam int SW = icas_pkg::ST_W;
   localparam int CW = icas_pkg::CUM_W;
   localparam logic [1:0] ACT_SAMPLE = 2'd2;
   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [1:0] action;
      logic [ZW-1:0] zen;
      logic [AZW-1:0] az;
      logic [WW-1:0] weight;
      logic [DW-1:0] draw;
      bit known;
      logic [ZW-1:0] exp_zen;
      logic [AZW-1:0] exp_az;
      logic [SW-1:0] exp_st;
   } stim_row;

   typedef struct {
      logic [ZW-1:0] zen;
      logic [AZW-1:0] az;
      logic [SW-1:0] st;
   } angle_result;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_action = icas_pkg::ACT_CLEAR;
   logic [ZW-1:0] req_bin_zenith = '0;
   logic [AZW-1:0] req_bin_azimuth = '0;
   logic [WW-1:0] req_bin_weight = '0;
   logic [DW-1:0] req_uniform_draw = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [ZW-1:0] rsp_out_zenith;
   logic [AZW-1:0] rsp_out_azimuth;
   logic [SW-1:0] rsp_status;

   logic [ZW-1:0] zen_bins [DEPTH];
   logic [AZW-1:0] az_bins [DEPTH];
   logic [CW-1:0] cum_bins [DEPTH];
   int unsigned bins_held;

   angle_result pending_results [$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit quiet_phase;
   bit timed_out = 0;

   always #5 clock = ~clock;

   inverse_cdf_angle_sampler dut (.*);

   function automatic logic [63:0] blend_q16(logic [63:0] v1, logic [63:0] v2,
                                            logic [63:0] alpha);
      return (v1 * (64'd65536 - alpha) + v2 * alpha + 64'd32768) >> 16;
   endfunction

   // updates the shadow table and returns the expected result
   function automatic angle_result predict_sample(stim_row r);
      angle_result res;
      logic [63:0] total, target, c1, c2, alpha, a1, a2, d;
      int unsigned lo, hi, mid;
      res = '{zen: '0, az: '0, st: icas_pkg::ST_NO_TABLE};
      if (r.action == icas_pkg::ACT_CLEAR) begin
         bins_held = 0;
         res.st = icas_pkg::ST_CLEARED;
      end else if (r.action == icas_pkg::ACT_LOAD) begin
         if (bins_held >= DEPTH) begin
            res.st = icas_pkg::ST_FULL;
         end else begin
            zen_bins[bins_held] = r.zen;
            az_bins[bins_held] = r.az;
            cum_bins[bins_held] = (bins_held == 0 ? '0 : cum_bins[bins_held-1]) +
                                  CW'(r.weight);
            bins_held++;
            res.st = icas_pkg::ST_STORED;
         end
      end else if (bins_held != 0 && cum_bins[bins_held-1] != 0) begin
         total = 64'(cum_bins[bins_held-1]);
         d = 64'(r.draw);
         target = d * (total >> 32) + ((d * (total & 64'hFFFF_FFFF)) >> 32);
         lo = 0;
         hi = bins_held - 1;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (64'(cum_bins[mid]) < target) lo = mid + 1;
            else hi = mid;
         end
         res.st = icas_pkg::ST_SAMPLED;
         if (lo == 0) begin
            res.zen = zen_bins[0];
            res.az = AZW'(64'(az_bins[0]) % 64'd46080);
         end else begin
            c1 = 64'(cum_bins[lo-1]);
            c2 = 64'(cum_bins[lo]);
            if (c2 <= c1 || target < c1) begin
               res.zen = zen_bins[lo];
               res.az = AZW'(64'(az_bins[lo]) % 64'd46080);
            end else begin
               alpha = ((target - c1) << 16) / (c2 - c1);
               if (alpha > 65536) alpha = 64'd65536;
               res.zen = ZW'(blend_q16(64'(zen_bins[lo-1]), 64'(zen_bins[lo]), alpha));
               a1 = 64'(az_bins[lo-1]);
               a2 = 64'(az_bins[lo]);
               if (a2 > a1) begin
                  if (a2 - a1 > 23040) a1 += 46080;
               end else begin
                  if (a1 - a2 > 23040) a2 += 46080;
               end
               res.az = AZW'(blend_q16(a1, a2, alpha) % 64'd46080);
            end
         end
      end
      return res;
   endfunction

   function automatic stim_row make_row(logic [1:0] act, int zen, int az,
                                        logic [31:0] w, logic [31:0] u);
      stim_row r;
      r = '{action: act, zen: ZW'(zen), az: AZW'(az), weight: w, draw: u, known: 0,
            exp_zen: '0, exp_az: '0, exp_st: '0};
      return r;
   endfunction

   function automatic stim_row fixed_row(logic [1:0] act, int zen, int az,
                                         logic [31:0] w, logic [31:0] u,
                                         int ez, int ea, logic [SW-1:0] es);
      stim_row r;
      r = make_row(act, zen, az, w, u);
      r.known = 1;
      r.exp_zen = ZW'(ez);
      r.exp_az = AZW'(ea);
      r.exp_st = es;
      return r;
   endfunction

   task automatic send_row(stim_row r);
      angle_result res;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid <= 1;
      req_action <= r.action;
      req_bin_zenith <= r.zen;
      req_bin_azimuth <= r.az;
      req_bin_weight <= r.weight;
      req_uniform_draw <= r.draw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = predict_sample(r);
      if (r.known && (res.zen != r.exp_zen || res.az != r.exp_az || res.st != r.exp_st))
         res = '{zen: r.exp_zen, az: r.exp_az, st: r.exp_st};
      pending_results = {pending_results, res};
      @(negedge clock);
   endtask

   task automatic send_random_load();
      logic [31:0] w;
      case ($urandom_range(0, 4))
         0: w = '0;
         1: w = 32'hFFFF_FFFF;
         2: w = 32'($urandom_range(0, 15));
         default: w = $urandom;
      endcase
      send_row(make_row(icas_pkg::ACT_LOAD, $urandom_range(0, 23040),
                        $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 46079),
                        w, $urandom));
   endtask

   // receiver: random stall bursts and the result check
   always @(negedge clock) begin
      if (!quiet_phase && !reset && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      rsp_stall <= 0;
   end

   always @(posedge clock) begin
      angle_result want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction status %0d", rsp_status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_zenith !== want.zen || rsp_out_azimuth !== want.az ||
                rsp_status !== want.st) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected zen %0d az %0d st %0d, got %0d %0d %0d",
                           want.zen, want.az, want.st,
                           rsp_out_zenith, rsp_out_azimuth, rsp_status);
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("inverse_cdf_angle_sampler test failed");
         $finish;
      end
   end

   initial begin
      stim_row plan [$];
      int n;
      quiet_phase = 0;
      bins_held = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      plan = {plan, fixed_row(ACT_SAMPLE, 0, 0, 0, 32'h8000_0000, 0, 0,
                              icas_pkg::ST_NO_TABLE)};
      plan = {plan, fixed_row(icas_pkg::ACT_LOAD, 23040, 46079, 0, 0, 0, 0,
                              icas_pkg::ST_STORED)};
      plan = {plan, fixed_row(ACT_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF, 0, 0,
                              icas_pkg::ST_NO_TABLE)};
      plan = {plan, fixed_row(icas_pkg::ACT_CLEAR, 32767, 65535, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 0, 0, icas_pkg::ST_CLEARED)};
      plan = {plan, fixed_row(icas_pkg::ACT_LOAD, 100, 65535, 32'hFFFF_FFFF, 0, 0, 0,
                              icas_pkg::ST_STORED)};
      plan = {plan, fixed_row(ACT_SAMPLE, 0, 0, 0, 0, 100, 65535 - 46080,
                              icas_pkg::ST_SAMPLED)};
      plan = {plan, fixed_row(icas_pkg::ACT_LOAD, 32767, 0, 32'hFFFF_FFFF, 0, 0, 0,
                              icas_pkg::ST_STORED)};
      plan = {plan, make_row(ACT_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF)};
      plan = {plan, make_row(ACT_SAMPLE, 0, 0, 0, 32'hC000_0000)};
      plan = {plan, make_row(ACT_SPARE, 0, 0, 0, 32'h8000_0001)};
      plan = {plan, fixed_row(icas_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0,
                              icas_pkg::ST_CLEARED)};
      plan = {plan, make_row(icas_pkg::ACT_LOAD, 0, 45000, 5, 0)};
      plan = {plan, make_row(icas_pkg::ACT_LOAD, 23040, 1000, 0, 0)};
      plan = {plan, make_row(icas_pkg::ACT_LOAD, 11520, 1000, 7, 0)};
      plan = {plan, make_row(ACT_SAMPLE, 0, 0, 0, 32'h4000_0000)};
      plan = {plan, make_row(ACT_SAMPLE, 0, 0, 0, 32'h6000_0000)};
      plan = {plan, make_row(ACT_SAMPLE, 0, 0, 0, 32'hE000_0000)};
      plan = {plan, make_row(ACT_SPARE, 0, 0, 0, 32'h0000_0001)};
      foreach (plan[i]) send_row(plan[i]);

      // random sets: usually a clear, then up to 12 loads and 1 to 10 samples or spare requests
      n = plan.size();
      while (n < 450) begin
         if (n > 380) quiet_phase = 1;
         if ($urandom_range(0, 9) != 0) begin
            send_row(make_row(icas_pkg::ACT_CLEAR, $urandom_range(0, 32767), $urandom,
                              $urandom, $urandom));
            n++;
         end
         repeat ($urandom_range(0, 12)) begin
            send_random_load();
            n++;
         end
         repeat ($urandom_range(1, 10)) begin
            send_row(make_row($urandom_range(0, 7) == 0 ? ACT_SPARE : ACT_SAMPLE,
                              $urandom_range(0, 32767), $urandom, $urandom, $urandom));
            n++;
         end
      end
      req_valid <= 0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("inverse_cdf_angle_sampler test passed");
      else
         $display("inverse_cdf_angle_sampler test failed");
      $finish;
   end
endmodule
